// File: sv/ucs_pkg.sv
package ucs_pkg;

	// one character of the URL
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} char_t;

	// one tagged character; summary fields are nonzero only with last_out
	typedef struct packed {
		logic [7:0]  out_byte;
		logic [2:0]  role;
		logic        last_out;
		logic [1:0]  scheme_code;
		logic [15:0] port_number;
		logic        path_defaulted;
		logic [1:0]  error_code;
	} tag_t;

	localparam logic [2:0] ROLE_SCHEME = 3'd0;
	localparam logic [2:0] ROLE_SEP    = 3'd1;
	localparam logic [2:0] ROLE_HOST   = 3'd2;
	localparam logic [2:0] ROLE_PORT   = 3'd3;
	localparam logic [2:0] ROLE_PATH   = 3'd4;

	localparam logic [1:0] SC_HTTP  = 2'd0;
	localparam logic [1:0] SC_HTTPS = 2'd1;
	localparam logic [1:0] SC_FILE  = 2'd2;
	localparam logic [1:0] SC_OTHER = 2'd3;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_NO_SEP  = 2'd1;
	localparam logic [1:0] ERR_NO_PORT = 2'd2;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [15:0] PORT_HTTP  = 16'd80;
	localparam logic [15:0] PORT_HTTPS = 16'd443;
	localparam logic [15:0] PORT_MAX   = 16'hFFFF;

endpackage

// File: sv/url_component_splitter_core.sv
// URL component splitter. Takes a URL one character per transaction on the
// char channel (in_last on the final character) and returns each character,
// in order, on the tag channel with its role: scheme, separator, host, port
// or path. The final transaction of a URL carries the scheme class (http,
// https, file, other), the parsed or default port, the defaulted-path flag
// and an error code; those fields read zero on all other transactions.
// A candidate ':' and '/' of "://" is held back and emitted later, so one
// character yields zero to three tag transactions. Results enter a
// four-entry result queue in the cycle after the character is taken; the
// queue drains one transaction per cycle while tag_stall is low. The block
// takes one character per cycle while at most one result is queued, so
// plain host and path characters stream at one per cycle with tag_stall
// low; the character that completes "://" or flushes a held ':' and '/'
// adds two or three results and raises char_stall until at most one is
// queued. char_stall is decoded from the queue count alone, not tag_stall.
module url_component_splitter_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          char_valid,
	output logic          char_stall,
	input  ucs_pkg::char_t char_data,
	output logic          tag_valid,
	input  logic          tag_stall,
	output ucs_pkg::tag_t  tag_data
);
	import ucs_pkg::*;

	// parse phase codes
	localparam logic [1:0] PH_SCHEME = 2'd0;
	localparam logic [1:0] PH_HOST   = 2'd1;
	localparam logic [1:0] PH_PORT   = 2'd2;
	localparam logic [1:0] PH_PATH   = 2'd3;

	typedef struct packed {
		logic [2:0] match;
		logic [2:0] len;
	} sch_t;

	// expected character of each candidate scheme at a position
	function automatic logic [2:0] cand_hit(input logic [2:0] pos, input logic [7:0] b);
		logic [2:0] hit;
		hit = 3'b000;
		unique case (pos)
			3'd0: begin
				hit[0] = (b == 8'h68);
				hit[1] = (b == 8'h68);
				hit[2] = (b == 8'h66);
			end
			3'd1: begin
				hit[0] = (b == 8'h74);
				hit[1] = (b == 8'h74);
				hit[2] = (b == 8'h69);
			end
			3'd2: begin
				hit[0] = (b == 8'h74);
				hit[1] = (b == 8'h74);
				hit[2] = (b == 8'h6C);
			end
			3'd3: begin
				hit[0] = (b == 8'h70);
				hit[1] = (b == 8'h70);
				hit[2] = (b == 8'h65);
			end
			3'd4: begin
				hit[1] = (b == 8'h73);
			end
			default: begin
				hit = 3'b000;
			end
		endcase
		return hit;
	endfunction

	function automatic sch_t sch_step(input sch_t s, input logic [7:0] b);
		sch_t r;
		r.match = s.match & cand_hit(s.len, b);
		r.len   = (s.len == 3'd7) ? s.len : s.len + 3'd1;
		return r;
	endfunction

	function automatic logic [1:0] sch_class(input sch_t s);
		logic [1:0] c;
		if (s.match[0] && s.len == 3'd4) begin
			c = SC_HTTP;
		end else if (s.match[1] && s.len == 3'd5) begin
			c = SC_HTTPS;
		end else if (s.match[2] && s.len == 3'd4) begin
			c = SC_FILE;
		end else begin
			c = SC_OTHER;
		end
		return c;
	endfunction

	function automatic tag_t mk_tag(input logic [7:0] b, input logic [2:0] role);
		tag_t t;
		t = '0;
		t.out_byte = b;
		t.role     = role;
		return t;
	endfunction

	// parser state
	logic [1:0]  phase_q;
	logic [1:0]  held_q;
	sch_t        sch_q;
	logic [15:0] port_q;
	logic        port_dig_q;
	logic        port_stop_q;
	logic        path_q;

	// result queue
	tag_t        fifo_q [4];
	logic [1:0]  wr_ptr_q;
	logic [1:0]  rd_ptr_q;
	logic [2:0]  count_q;

	logic        take;
	logic        pop;

	logic [1:0]  phase_n;
	logic [1:0]  held_n;
	sch_t        sch_n;
	logic [15:0] port_n;
	logic        port_dig_n;
	logic        port_stop_n;
	logic        path_n;
	tag_t        res [3];
	logic [1:0]  nres;
	logic [19:0] port_mac;
	logic [1:0]  sc;
	logic [7:0]  b;
	logic        last;

	assign b    = char_data.in_byte;
	assign last = char_data.in_last;

	// next character only while at most one result is queued: room for three
	assign char_stall = (count_q > 3'd1);
	assign take       = char_valid && !char_stall;

	assign tag_valid = (count_q != 3'd0);
	assign tag_data  = fifo_q[rd_ptr_q];
	assign pop       = tag_valid && !tag_stall;

	assign port_mac = {1'b0, port_q, 3'b000} + {3'b000, port_q, 1'b0} + {12'd0, b - CH_ZERO};

	always_comb begin
		phase_n     = phase_q;
		held_n      = held_q;
		sch_n       = sch_q;
		port_n      = port_q;
		port_dig_n  = port_dig_q;
		port_stop_n = port_stop_q;
		path_n      = path_q;
		res[0]      = '0;
		res[1]      = '0;
		res[2]      = '0;
		nres        = 2'd0;
		sc          = SC_OTHER;

		unique case (phase_q)
			PH_SCHEME: begin
				if (held_q == 2'd2 && b == CH_SLASH) begin
					res[0] = mk_tag(CH_COLON, ROLE_SEP);
					res[1] = mk_tag(CH_SLASH, ROLE_SEP);
					res[2] = mk_tag(CH_SLASH, ROLE_SEP);
					nres   = 2'd3;
					held_n = 2'd0;
					if (sch_class(sch_q) == SC_FILE) begin
						phase_n = PH_PATH;
						path_n  = 1'b1;
					end else begin
						phase_n = PH_HOST;
					end
				end else if (held_q == 2'd1 && b == CH_SLASH && !last) begin
					held_n = 2'd2;
				end else begin
					// failed match: held bytes go out as scheme bytes first
					if (held_q != 2'd0) begin
						sch_n     = sch_step(sch_n, CH_COLON);
						res[nres] = mk_tag(CH_COLON, ROLE_SCHEME);
						nres      = nres + 2'd1;
					end
					if (held_q == 2'd2) begin
						sch_n     = sch_step(sch_n, CH_SLASH);
						res[nres] = mk_tag(CH_SLASH, ROLE_SCHEME);
						nres      = nres + 2'd1;
					end
					held_n = 2'd0;
					if (b == CH_COLON && !last) begin
						held_n = 2'd1;
					end else begin
						sch_n     = sch_step(sch_n, b);
						res[nres] = mk_tag(b, ROLE_SCHEME);
						nres      = nres + 2'd1;
					end
				end
			end
			PH_HOST: begin
				nres = 2'd1;
				if (b == CH_SLASH) begin
					phase_n = PH_PATH;
					path_n  = 1'b1;
					res[0]  = mk_tag(b, ROLE_PATH);
				end else if (b == CH_COLON) begin
					phase_n = PH_PORT;
					res[0]  = mk_tag(b, ROLE_PORT);
				end else begin
					res[0]  = mk_tag(b, ROLE_HOST);
				end
			end
			PH_PORT: begin
				nres = 2'd1;
				if (b == CH_SLASH) begin
					phase_n = PH_PATH;
					path_n  = 1'b1;
					res[0]  = mk_tag(b, ROLE_PATH);
				end else begin
					if (!port_stop_q && b >= CH_ZERO && b <= CH_NINE) begin
						port_n     = (port_mac > 20'(PORT_MAX)) ? PORT_MAX : port_mac[15:0];
						port_dig_n = 1'b1;
					end else begin
						port_stop_n = 1'b1;
					end
					res[0] = mk_tag(b, ROLE_PORT);
				end
			end
			PH_PATH: begin
				nres   = 2'd1;
				res[0] = mk_tag(b, ROLE_PATH);
			end
			default: begin
				nres = 2'd0;
			end
		endcase

		// summary on the final result of the URL, then back to reset state
		if (last && nres != 2'd0) begin
			res[nres - 2'd1].last_out = 1'b1;
			if (phase_n == PH_SCHEME) begin
				res[nres - 2'd1].scheme_code = SC_OTHER;
				res[nres - 2'd1].error_code  = ERR_NO_SEP;
			end else begin
				sc = sch_class(sch_n);
				res[nres - 2'd1].scheme_code = sc;
				if (sc != SC_FILE) begin
					res[nres - 2'd1].path_defaulted = !path_n;
					if (port_dig_n) begin
						res[nres - 2'd1].port_number = port_n;
					end else if (phase_n == PH_PORT || port_stop_n) begin
						res[nres - 2'd1].error_code = ERR_NO_PORT;
					end else begin
						res[nres - 2'd1].port_number = (sc == SC_HTTP) ? PORT_HTTP : PORT_HTTPS;
					end
				end
			end
			phase_n     = PH_SCHEME;
			held_n      = 2'd0;
			sch_n.match = 3'b111;
			sch_n.len   = 3'd0;
			port_n      = '0;
			port_dig_n  = 1'b0;
			port_stop_n = 1'b0;
			path_n      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SCHEME;
			held_q      <= 2'd0;
			sch_q.match <= 3'b111;
			sch_q.len   <= 3'd0;
			port_q      <= '0;
			port_dig_q  <= 1'b0;
			port_stop_q <= 1'b0;
			path_q      <= 1'b0;
		end else if (take) begin
			phase_q     <= phase_n;
			held_q      <= held_n;
			sch_q       <= sch_n;
			port_q      <= port_n;
			port_dig_q  <= port_dig_n;
			port_stop_q <= port_stop_n;
			path_q      <= path_n;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			if (take) begin
				wr_ptr_q <= wr_ptr_q + nres;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + (take ? {1'b0, nres} : 3'd0) - {2'b00, pop};
		end
	end

	// queue payload, up to three entries written per taken character
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (take && 2'(i) < nres) begin
				fifo_q[wr_ptr_q + 2'(i)] <= res[i];
			end
		end
	end

endmodule

// File: sv/ucs_checker.sv
module ucs_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           char_valid,
	input logic           char_stall,
	input ucs_pkg::char_t char_data,
	input logic           tag_valid,
	input logic           tag_stall,
	input ucs_pkg::tag_t  tag_data
);
	import ucs_pkg::*;

	// a pending tag transaction is not withdrawn
	a_tag_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tag_valid && tag_stall |=> tag_valid)
		else $error("tag_valid dropped while stalled");

	// with nothing queued the char side is always open
	a_open_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!tag_valid |-> !char_stall)
		else $error("char_stall with empty result queue");

	// the final character always produces at least one result
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_stall && char_data.in_last |=> tag_valid)
		else $error("final character produced no result");

	// summary fields are zero except on the final result
	a_summary_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tag_valid && !tag_data.last_out |->
			tag_data.scheme_code == SC_HTTP && tag_data.port_number == 16'd0 &&
			!tag_data.path_defaulted && tag_data.error_code == ERR_NONE)
		else $error("summary fields set on a non-final result");

	// a separator error means no recognized scheme and no port
	a_nosep_fields: assert property (@(posedge clk) disable iff (!arst_n)
		tag_valid && tag_data.error_code == ERR_NO_SEP |->
			tag_data.scheme_code == SC_OTHER && tag_data.port_number == 16'd0)
		else $error("inconsistent summary on missing separator");

endmodule

bind url_component_splitter_core ucs_checker u_ucs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.char_valid (char_valid),
	.char_stall (char_stall),
	.char_data  (char_data),
	.tag_valid  (tag_valid),
	.tag_stall  (tag_stall),
	.tag_data   (tag_data)
);

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import ucs_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int STIM_CHARS = 210;

	logic clk;
	logic arst_n;
	logic char_valid = 1'b0;
	logic char_stall;
	char_t char_data = '0;
	logic tag_valid;
	logic tag_stall = 1'b0;
	tag_t tag_data;

	url_component_splitter_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_data(char_data),
		.tag_valid(tag_valid),
		.tag_stall(tag_stall),
		.tag_data(tag_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Parser shadow: tracks where we are in the URL and tags each char
	// ------------------------------------------------------------------
	typedef enum logic [1:0] {IN_SCHEME, IN_HOST, IN_PORT, IN_PATH} url_phase_e;

	url_phase_e phase_q = IN_SCHEME;
	logic [1:0] held_n = '0;      // held bytes of a partial "://"
	logic [2:0] scheme_len = '0;  // saturates at 7
	logic [2:0] scheme_hits = 3'b111; // bit0 http, bit1 https, bit2 file
	logic [15:0] port_acc = '0;
	logic port_digit = 1'b0;
	logic port_done = 1'b0;
	logic path_seen = 1'b0;

	// tags produced by the char being processed (zero to three)
	tag_t step_tags [3];
	int step_n;

	tag_t tags_due [$];       // tags the block still owes us, oldest first
	char_t url_chars [$];     // chars not yet presented to the block
	logic [7:0] url_buf [$];  // URL under construction
	int chars_taken = 0;
	int stim_total = 0;
	int mismatches = 0;
	int cycles = 0;

	task automatic parser_clear();
		phase_q = IN_SCHEME;
		held_n = '0;
		scheme_len = '0;
		scheme_hits = 3'b111;
		port_acc = '0;
		port_digit = 1'b0;
		port_done = 1'b0;
		path_seen = 1'b0;
	endtask

	task automatic put_tag(input logic [7:0] b, input logic [2:0] r);
		if (step_n < 3) begin
			step_tags[step_n] = '0;
			step_tags[step_n].out_byte = b;
			step_tags[step_n].role = r;
			step_n++;
		end
	endtask

	function automatic logic cand_ok(input string word, input int pos, input logic [7:0] b);
		return pos < word.len() && word[pos] == b;
	endfunction

	task automatic scheme_char(input logic [7:0] b);
		if (!cand_ok("http", int'(scheme_len), b)) scheme_hits[0] = 1'b0;
		if (!cand_ok("https", int'(scheme_len), b)) scheme_hits[1] = 1'b0;
		if (!cand_ok("file", int'(scheme_len), b)) scheme_hits[2] = 1'b0;
		if (scheme_len < 3'd7) scheme_len++;
		put_tag(b, ROLE_SCHEME);
	endtask

	function automatic logic [1:0] scheme_kind();
		if (scheme_hits[0] && scheme_len == 3'd4) return SC_HTTP;
		if (scheme_hits[1] && scheme_len == 3'd5) return SC_HTTPS;
		if (scheme_hits[2] && scheme_len == 3'd4) return SC_FILE;
		return SC_OTHER;
	endfunction

	// Works out the tags one accepted char causes and queues them.
	task automatic predict_tags(input char_t c);
		logic [7:0] b;
		logic fin;
		int v;
		logic [1:0] sc;
		logic [1:0] err;
		logic [15:0] port;
		logic pd;
		b = c.in_byte;
		fin = c.in_last;
		step_n = 0;
		case (phase_q)
			IN_SCHEME: begin
				if (held_n == 2'd2 && b == CH_SLASH) begin
					// "://" complete
					put_tag(CH_COLON, ROLE_SEP);
					put_tag(CH_SLASH, ROLE_SEP);
					put_tag(CH_SLASH, ROLE_SEP);
					held_n = '0;
					if (scheme_kind() == SC_FILE) begin
						phase_q = IN_PATH;
						path_seen = 1'b1;
					end else begin
						phase_q = IN_HOST;
					end
				end else if (held_n == 2'd1 && b == CH_SLASH && !fin) begin
					held_n = 2'd2;
				end else begin
					// match broken (or URL ends): held bytes go out as scheme
					if (held_n >= 2'd1) scheme_char(CH_COLON);
					if (held_n >= 2'd2) scheme_char(CH_SLASH);
					held_n = '0;
					if (b == CH_COLON && !fin) held_n = 2'd1;
					else scheme_char(b);
				end
			end
			IN_HOST: begin
				if (b == CH_SLASH) begin
					phase_q = IN_PATH;
					path_seen = 1'b1;
					put_tag(b, ROLE_PATH);
				end else if (b == CH_COLON) begin
					phase_q = IN_PORT;
					put_tag(b, ROLE_PORT);
				end else begin
					put_tag(b, ROLE_HOST);
				end
			end
			IN_PORT: begin
				if (b == CH_SLASH) begin
					phase_q = IN_PATH;
					path_seen = 1'b1;
					put_tag(b, ROLE_PATH);
				end else begin
					if (!port_done && b >= CH_ZERO && b <= CH_NINE) begin
						v = int'(port_acc) * 10 + int'(b - CH_ZERO);
						port_acc = (v > 65535) ? PORT_MAX : v[15:0];
						port_digit = 1'b1;
					end else begin
						port_done = 1'b1;
					end
					put_tag(b, ROLE_PORT);
				end
			end
			default: put_tag(b, ROLE_PATH);
		endcase

		// summary rides on the final tag of the URL
		if (fin && step_n > 0) begin
			sc = SC_OTHER;
			err = ERR_NONE;
			pd = 1'b0;
			port = '0;
			if (phase_q == IN_SCHEME) begin
				err = ERR_NO_SEP;
			end else begin
				sc = scheme_kind();
				if (sc != SC_FILE) begin
					pd = !path_seen;
					if (port_digit) port = port_acc;
					else if (phase_q == IN_PORT || port_done) err = ERR_NO_PORT;
					else port = (sc == SC_HTTP) ? PORT_HTTP : PORT_HTTPS;
				end
			end
			step_tags[step_n - 1].last_out = 1'b1;
			step_tags[step_n - 1].scheme_code = sc;
			step_tags[step_n - 1].port_number = port;
			step_tags[step_n - 1].path_defaulted = pd;
			step_tags[step_n - 1].error_code = err;
			parser_clear();
		end
		for (int i = 0; i < step_n; i++) tags_due.push_back(step_tags[i]);
	endtask

	task automatic report(input string what, input int got, input int want);
		mismatches++;
		// cap the log; every mismatch still counts
		if (mismatches <= 100)
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// ------------------------------------------------------------------
	// Stimulus construction
	// ------------------------------------------------------------------
	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) url_buf.push_back(s[i]);
	endtask

	// moves the URL under construction into the send queue, last flag on its final char
	task automatic commit_url();
		char_t c;
		if (url_buf.size() == 0) url_buf.push_back(8'h61);
		for (int i = 0; i < url_buf.size(); i++) begin
			c.in_byte = url_buf[i];
			c.in_last = (i == url_buf.size() - 1);
			url_chars.push_back(c);
		end
		url_buf.delete();
	endtask

	task automatic add_chars(input string pool, input int n);
		repeat (n) url_buf.push_back(pool[$urandom_range(0, pool.len() - 1)]);
	endtask

	// Mostly well-formed URLs with random content; some near-miss schemes,
	// broken separators and raw noise mixed in.
	task automatic make_random_url();
		int n;
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 6);
			repeat (n) url_buf.push_back(8'($urandom_range(0, 255)));
		end else begin
			case ($urandom_range(0, 7))
				0, 1: add_text("http");
				2: add_text("https");
				3: add_text("file");
				4: add_text("HTTP");
				5: begin
					case ($urandom_range(0, 3))
						0: add_text("htt");
						1: add_text("httpsx");
						2: add_text("fil");
						default: add_text("filex");
					endcase
				end
				default: add_chars("abfhiltpsz09:/", $urandom_range(0, 6));
			endcase
			case ($urandom_range(0, 9))
				0: add_text(":/");
				1: add_text(":");
				2: add_text("//");
				3: add_text(":/:/");
				4: add_text("::/");
				default: add_text("://");
			endcase
			add_chars("abcxyz0189.-AZ", $urandom_range(0, 4));
			if ($urandom_range(0, 2) == 0) begin
				url_buf.push_back(CH_COLON);
				add_chars("0123456789", $urandom_range(0, 6));
				if ($urandom_range(0, 3) == 0) begin
					add_chars("ax:.", 1);
					add_chars("0123456789", $urandom_range(0, 2));
				end
			end
			if ($urandom_range(0, 2) != 0) begin
				url_buf.push_back(CH_SLASH);
				n = $urandom_range(0, 4);
				repeat (n) url_buf.push_back(8'($urandom_range(0, 255)));
			end
		end
		commit_url();
	endtask

	// ------------------------------------------------------------------
	// Driver: bursts of chars with random gaps between them
	// ------------------------------------------------------------------
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (char_valid && !char_stall) begin
				predict_tags(char_data);
				chars_taken++;
			end
			// only move on once the current transaction is gone
			if (!char_valid || !char_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					char_valid <= 1'b0;
				end else if (url_chars.size() > 0) begin
					char_data <= url_chars.pop_front();
					char_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					char_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each tag transaction, drives its own stall pattern
	// ------------------------------------------------------------------
	int stall_mode = 0;
	int stall_left = 0;

	always @(posedge clk) begin : tag_mon
		tag_t want;
		if (arst_n) begin
			if (tag_valid && !tag_stall) begin
				if (tags_due.size() == 0) begin
					report("tag with nothing outstanding", int'(tag_data.out_byte), -1);
				end else begin
					want = tags_due.pop_front();
					if (tag_data.out_byte !== want.out_byte)
						report("out_byte", int'(tag_data.out_byte), int'(want.out_byte));
					if (tag_data.role !== want.role)
						report("role", int'(tag_data.role), int'(want.role));
					if (tag_data.last_out !== want.last_out)
						report("last_out", int'(tag_data.last_out), int'(want.last_out));
					if (tag_data.scheme_code !== want.scheme_code)
						report("scheme_code", int'(tag_data.scheme_code), int'(want.scheme_code));
					if (tag_data.port_number !== want.port_number)
						report("port_number", int'(tag_data.port_number), int'(want.port_number));
					if (tag_data.path_defaulted !== want.path_defaulted)
						report("path_defaulted", int'(tag_data.path_defaulted),
							int'(want.path_defaulted));
					if (tag_data.error_code !== want.error_code)
						report("error_code", int'(tag_data.error_code), int'(want.error_code));
				end
			end
			// stall pattern: stretches of none, light random, or heavy stalling
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_left = $urandom_range(10, 60);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				0: tag_stall <= 1'b0;
				1: tag_stall <= ($urandom_range(0, 2) == 0);
				default: tag_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus, reset and end of run
	// ------------------------------------------------------------------
	initial begin
		// directed: file with empty path, ':' then '/' on the final char,
		// lone ':' as final char, byte extremes with no separator,
		// port with no digits, overlong port
		add_text("file://");
		commit_url();
		add_text("a:/");
		commit_url();
		add_text(":");
		commit_url();
		url_buf.push_back(8'hFF);
		url_buf.push_back(8'h00);
		commit_url();
		add_text("s://:z");
		commit_url();
		add_text("p://:70000");
		commit_url();
		while (url_chars.size() < STIM_CHARS) make_random_url();
		stim_total = url_chars.size();

		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// sample at the falling edge so the clocked blocks have settled
		while (chars_taken < stim_total) @(negedge clk);
		while (tags_due.size() > 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: files.f
sv/ucs_pkg.sv
sv/url_component_splitter_core.sv
sv/ucs_checker.sv
sim/tb.sv
